// ===== sv/ps2kh_pkg.sv =====
// shared types, codes and constants for the ps2 keyboard host bring-up controller
package ps2kh_pkg;

    // beat kinds on the input channel
    localparam logic [1:0] ACT_FRAME = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_POLL  = 2'd2;

    // bytes seen on the wire
    localparam logic [7:0] B_BAT       = 8'hAA;
    localparam logic [7:0] B_ACK       = 8'hFA;
    localparam logic [7:0] B_RESEND    = 8'hFE;
    localparam logic [7:0] B_RESET     = 8'hFF;
    localparam logic [7:0] B_GETID     = 8'hF2;
    localparam logic [7:0] B_SETLEDS   = 8'hED;
    localparam logic [7:0] B_MAKEBREAK = 8'hF8;
    localparam logic [7:0] B_CONNECT   = 8'h54;

    localparam logic [15:0] ID_UNKNOWN = 16'hFFFF;

    // stall counter limits
    localparam logic [2:0] STALL_LIMIT         = 3'd2;
    localparam logic [2:0] STALL_MAX           = 3'd7;
    localparam logic [3:0] DEF_DETECT_ATTEMPTS = 4'd5;

    // controller phases, one-hot
    typedef enum logic [7:0] {
        PH_UNINIT   = 8'b0000_0001,
        PH_ACK      = 8'b0000_0010,
        PH_SELFTEST = 8'b0000_0100,
        PH_ID1      = 8'b0000_1000,
        PH_ID2      = 8'b0001_0000,
        PH_SETUP    = 8'b0010_0000,
        PH_LEDS     = 8'b0100_0000,
        PH_READY    = 8'b1000_0000
    } t_phase;

    // external phase codes
    localparam logic [2:0] PC_UNINIT   = 3'd0;
    localparam logic [2:0] PC_ACK      = 3'd1;
    localparam logic [2:0] PC_SELFTEST = 3'd2;
    localparam logic [2:0] PC_ID1      = 3'd3;
    localparam logic [2:0] PC_ID2      = 3'd4;
    localparam logic [2:0] PC_SETUP    = 3'd5;
    localparam logic [2:0] PC_LEDS     = 3'd6;
    localparam logic [2:0] PC_READY    = 3'd7;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_data;
        logic       frame_start;
        logic       frame_parity;
        logic       clock_line_high;
        logic [2:0] host_lock_leds;
    } t_in_beat;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        scan_valid;
        logic [7:0]  scan_code;
        logic        restart_receiver;
        logic        ready_res;
        logic [15:0] kbd_id;
        logic [2:0]  phase;
    } t_result;

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        case (ph)
            PH_UNINIT:   code = PC_UNINIT;
            PH_ACK:      code = PC_ACK;
            PH_SELFTEST: code = PC_SELFTEST;
            PH_ID1:      code = PC_ID1;
            PH_ID2:      code = PC_ID2;
            PH_SETUP:    code = PC_SETUP;
            PH_LEDS:     code = PC_LEDS;
            PH_READY:    code = PC_READY;
            default:     code = PC_UNINIT;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/ps2_keyboard_host_init_fsm.sv =====
// top level of the ps2 keyboard host bring-up controller
// Host-side bring-up controller for an AT/PS2 keyboard. Each input beat is a
// received frame, a detection tick carrying the clock-line level, or a
// lock-LED poll, and each beat yields exactly one result beat: a command byte
// to send (reset, get-id, set-leds, make/break-all, resend, LED bitmap), a
// forwarded scan code once initialised, a receiver-restart flag, the current
// phase and the assembled 16-bit keyboard id. Frames are checked for a zero
// start bit and odd parity. A beat is taken into an input register, then
// the phase logic and state update run combinationally from it into the
// output register, so a beat is accepted every cycle unless o_in_stall is
// high; the output register lets the next beat enter while a result still
// waits, and the input stalls only once both registers are full. The user
// must write i_cfg_wr_data (sets terminal_set3, make/break-all setup after
// the id) only while the block is idle; the block does not enforce this.
module ps2_keyboard_host_init_fsm
    import ps2kh_pkg::*;
#(
    parameter logic [3:0] DETECT_ATTEMPTS = DEF_DETECT_ATTEMPTS
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,

    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_rx_data,
    input  logic        i_frame_start,
    input  logic        i_frame_parity,
    input  logic        i_clock_line_high,
    input  logic [2:0]  i_host_lock_leds,

    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_send_valid,
    output logic [7:0]  o_send_byte,
    output logic        o_scan_valid,
    output logic [7:0]  o_scan_code,
    output logic        o_restart_receiver,
    output logic        o_ready_res,
    output logic [15:0] o_kbd_id,
    output logic [2:0]  o_phase
);

    logic     r_terminal_set3;
    t_in_beat in_beat;
    t_in_beat stage_beat;
    logic     stage_valid;
    logic     can_load;
    logic     fire;
    t_result  step_result;
    t_result  out_result;

    // mode bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_terminal_set3 <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_terminal_set3 <= i_cfg_wr_data;
        end
    end

    always_comb begin
        in_beat.action          = i_action;
        in_beat.rx_data         = i_rx_data;
        in_beat.frame_start     = i_frame_start;
        in_beat.frame_parity    = i_frame_parity;
        in_beat.clock_line_high = i_clock_line_high;
        in_beat.host_lock_leds  = i_host_lock_leds;
    end

    // staged beat is processed whenever the output register has room
    assign fire = stage_valid && can_load;

    ps2kh_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_beat    (in_beat),
        .i_advance (can_load),
        .o_stall   (o_in_stall),
        .o_valid   (stage_valid),
        .o_beat    (stage_beat)
    );

    ps2kh_step #(
        .DETECT_ATTEMPTS (DETECT_ATTEMPTS)
    ) u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_beat          (stage_beat),
        .i_terminal_set3 (r_terminal_set3),
        .o_result        (step_result)
    );

    ps2kh_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_result   (step_result),
        .i_stall    (i_out_stall),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .o_result   (out_result)
    );

    assign o_send_valid       = out_result.send_valid;
    assign o_send_byte        = out_result.send_byte;
    assign o_scan_valid       = out_result.scan_valid;
    assign o_scan_code        = out_result.scan_code;
    assign o_restart_receiver = out_result.restart_receiver;
    assign o_ready_res        = out_result.ready_res;
    assign o_kbd_id           = out_result.kbd_id;
    assign o_phase            = out_result.phase;

    // scan codes are only forwarded while initialised
    a_scan_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scan_valid |-> o_ready_res && o_phase == PC_READY)
        else $error("scan code forwarded outside initialised phase");

    // a receiver restart always drops back to the uninitialised phase
    a_restart_uninit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_restart_receiver |-> o_phase == PC_UNINIT && !o_scan_valid)
        else $error("receiver restart without return to uninit");

    // never a command and a scan code in the same beat
    a_send_xor_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_send_valid && o_scan_valid))
        else $error("send and scan in one result beat");

    // a staged beat with room downstream shows up as a result next cycle
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_valid && (!o_out_valid || !i_out_stall) |=> o_out_valid)
        else $error("staged beat lost");

endmodule

// ===== sv/ps2kh_in_reg.sv =====
// input register stage holding one accepted beat
module ps2kh_in_reg
    import ps2kh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    input  logic     i_advance,
    output logic     o_stall,
    output logic     o_valid,
    output t_in_beat o_beat
);

    logic     r_valid;
    logic     n_valid;
    t_in_beat r_beat;
    logic     take;

    assign o_stall = r_valid && !i_advance;
    assign take    = i_valid && !o_stall;
    assign n_valid = take || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== sv/ps2kh_step.sv =====
// controller state and the per-beat next-state and result logic
module ps2kh_step
    import ps2kh_pkg::*;
#(
    parameter logic [3:0] DETECT_ATTEMPTS = DEF_DETECT_ATTEMPTS
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_beat i_beat,
    input  logic     i_terminal_set3,
    output t_result  o_result
);

    t_phase      r_phase,   n_phase;
    logic [15:0] r_id,      n_id;
    logic [2:0]  r_leds,    n_leds;
    logic        r_retried, n_retried;
    logic [2:0]  r_stall,   n_stall;

    logic        snd_v, scn_v, rst;
    logic [7:0]  snd_b, scn_b;
    logic [2:0]  stall_inc;
    logic        bad_parity;
    logic [7:0]  d;

    assign d          = i_beat.rx_data;
    assign bad_parity = i_beat.frame_parity != ~(^d);
    assign stall_inc  = (r_stall == STALL_MAX) ? r_stall : r_stall + 3'd1;

    always_comb begin
        n_phase   = r_phase;
        n_id      = r_id;
        n_leds    = r_leds;
        n_retried = r_retried;
        n_stall   = r_stall;
        snd_v     = 1'b0;
        snd_b     = '0;
        scn_v     = 1'b0;
        scn_b     = '0;
        rst       = 1'b0;
        case (i_beat.action)
            ACT_FRAME: begin
                if (bad_parity) begin
                    // connect artifact also restarts bring-up
                    if (d == B_CONNECT && i_beat.frame_parity) begin
                        n_phase   = PH_UNINIT;
                        n_retried = 1'b0;
                        rst       = 1'b1;
                    end
                    snd_v = 1'b1;
                    snd_b = B_RESEND;
                end else if (i_beat.frame_start) begin
                    n_phase   = PH_UNINIT;
                    n_retried = 1'b0;
                    rst       = 1'b1;
                end else begin
                    case (r_phase)
                        PH_UNINIT: begin
                            n_retried = 1'b0;
                            n_id      = ID_UNKNOWN;
                            if (d == B_BAT) begin
                                n_leds  = '0;
                                n_phase = PH_ID1;
                            end else begin
                                n_phase = PH_ACK;
                                snd_v   = 1'b1;
                                snd_b   = B_RESET;
                            end
                        end
                        PH_ACK: begin
                            if (d == B_ACK) begin
                                n_phase = PH_SELFTEST;
                            end else begin
                                snd_v = 1'b1;
                                snd_b = B_RESET;
                            end
                        end
                        PH_SELFTEST: begin
                            if (d == B_BAT) begin
                                n_leds  = '0;
                                n_phase = PH_ID1;
                            end else begin
                                n_phase = PH_ACK;
                                snd_v   = 1'b1;
                                snd_b   = B_RESET;
                            end
                        end
                        PH_ID1: begin
                            if (d != B_ACK) begin
                                n_id    = {d, r_id[7:0]};
                                n_phase = PH_ID2;
                            end
                        end
                        PH_ID2: begin
                            n_id = {r_id[15:8], d};
                            if (i_terminal_set3) begin
                                snd_v   = 1'b1;
                                snd_b   = B_MAKEBREAK;
                                n_phase = PH_SETUP;
                            end else begin
                                n_phase = PH_READY;
                            end
                        end
                        PH_SETUP: begin
                            if (d != B_ACK) begin
                                n_id = ID_UNKNOWN;
                            end
                            n_phase = PH_READY;
                        end
                        PH_LEDS: begin
                            if (d == B_ACK && i_beat.host_lock_leds != r_leds) begin
                                n_leds = i_beat.host_lock_leds;
                                snd_v  = 1'b1;
                                snd_b  = {5'd0, i_beat.host_lock_leds};
                            end else begin
                                if (d != B_ACK) begin
                                    n_leds = i_beat.host_lock_leds;
                                end
                                n_phase = PH_READY;
                            end
                        end
                        default: begin
                            scn_v = 1'b1;
                            scn_b = d;
                        end
                    endcase
                end
            end
            ACT_TICK: begin
                if (r_phase != PH_READY) begin
                    if (i_beat.clock_line_high) begin
                        n_stall = stall_inc;
                        if (r_phase inside {PH_ID1, PH_ID2, PH_SETUP}) begin
                            if (stall_inc > STALL_LIMIT) begin
                                if (!r_retried) begin
                                    n_retried = 1'b1;
                                    n_phase   = PH_ID1;
                                    snd_v     = 1'b1;
                                    snd_b     = B_GETID;
                                end else begin
                                    n_id    = ID_UNKNOWN;
                                    n_phase = PH_READY;
                                end
                                n_stall = '0;
                            end
                        end else if (r_phase == PH_LEDS) begin
                            if (stall_inc > STALL_LIMIT) begin
                                n_phase = PH_READY;
                                n_stall = '0;
                            end
                        end else if ({1'b0, stall_inc} >= DETECT_ATTEMPTS) begin
                            n_phase = PH_ACK;
                            n_stall = '0;
                            snd_v   = 1'b1;
                            snd_b   = B_RESET;
                        end
                    end else if (r_phase == PH_UNINIT) begin
                        n_stall = '0;
                    end
                end
            end
            ACT_POLL: begin
                if (r_phase == PH_READY) begin
                    n_stall = '0;
                    if (i_beat.host_lock_leds != r_leds) begin
                        n_phase = PH_LEDS;
                        snd_v   = 1'b1;
                        snd_b   = B_SETLEDS;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_UNINIT;
            r_id      <= ID_UNKNOWN;
            r_leds    <= '0;
            r_retried <= 1'b0;
            r_stall   <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_id      <= n_id;
            r_leds    <= n_leds;
            r_retried <= n_retried;
            r_stall   <= n_stall;
        end
    end

    always_comb begin
        o_result.send_valid       = snd_v;
        o_result.send_byte        = snd_b;
        o_result.scan_valid       = scn_v;
        o_result.scan_code        = scn_b;
        o_result.restart_receiver = rst;
        o_result.ready_res        = n_phase == PH_READY;
        o_result.kbd_id           = n_id;
        o_result.phase            = phase_code(n_phase);
    end

endmodule

// ===== sv/ps2kh_out_reg.sv =====
// output register holding one result beat until it is taken
module ps2kh_out_reg
    import ps2kh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_can_load = !r_valid || !i_stall;
    assign n_valid    = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
